// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CHK_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== src/ctig_pkg.sv =====
package ctig_pkg;

  localparam int MAX_RINGS    = 256;
  localparam int MAX_SEGMENTS = 256;

  localparam int CNT_W  = 9;    // configuration register width
  localparam int IDX_W  = 17;   // vertex index width
  localparam int RP_W   = $clog2(MAX_RINGS - 1);
  localparam int SP_W   = $clog2(MAX_SEGMENTS);
  localparam int CIDX_W = 1;

  localparam logic [CIDX_W-1:0] CFG_RING_COUNT    = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_SEGMENT_COUNT = CIDX_W'(1);

  typedef enum logic [1:0] {
    REG_TOP,
    REG_BAND,
    REG_BOTTOM
  } region_e;

  typedef struct packed {
    logic [CNT_W-1:0] rings;
    logic [CNT_W-1:0] segs;
  } ctig_cfg_t;

  typedef struct packed {
    region_e          region;
    logic [RP_W-1:0]  ring_pos;
    logic [SP_W-1:0]  seg_pos;
    logic             band_half;
    logic [IDX_W-1:0] row_base;
  } ctig_state_t;

  typedef struct packed {
    logic [IDX_W-1:0] corner_a;
    logic [IDX_W-1:0] corner_b;
    logic [IDX_W-1:0] corner_c;
    logic             mesh_last;
  } ctig_tri_t;

  localparam ctig_state_t SEQ_RESET = '{
    region:    REG_TOP,
    ring_pos:  '0,
    seg_pos:   '0,
    band_half: 1'b0,
    row_base:  IDX_W'(1)
  };

endpackage

// ===== src/ctig_if.sv =====
interface ctig_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface ctig_out_if import ctig_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] corner_a;
  logic [IDX_W-1:0] corner_b;
  logic [IDX_W-1:0] corner_c;
  logic             mesh_last;

  modport source (output valid, output corner_a, output corner_b, output corner_c,
                  output mesh_last, input ready);
  modport sink (input valid, input corner_a, input corner_b, input corner_c,
                input mesh_last, output ready);
endinterface

interface ctig_cfg_if import ctig_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CNT_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/ctig_cfg.sv =====
module ctig_cfg import ctig_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctig_cfg_if.sink   cfg_i,
  output ctig_cfg_t  cfg_o
);

  logic [CNT_W-1:0] ring_count_q;
  logic [CNT_W-1:0] segment_count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_count_q    <= CNT_W'(2);
      segment_count_q <= CNT_W'(3);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_RING_COUNT:    ring_count_q    <= cfg_i.data;
        CFG_SEGMENT_COUNT: segment_count_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // registers keep the raw bits, the values in use are clamped
  always_comb begin
    if (ring_count_q < CNT_W'(2)) begin
      cfg_o.rings = CNT_W'(2);
    end else if (ring_count_q > CNT_W'(MAX_RINGS)) begin
      cfg_o.rings = CNT_W'(MAX_RINGS);
    end else begin
      cfg_o.rings = ring_count_q;
    end
    if (segment_count_q < CNT_W'(3)) begin
      cfg_o.segs = CNT_W'(3);
    end else if (segment_count_q > CNT_W'(MAX_SEGMENTS)) begin
      cfg_o.segs = CNT_W'(MAX_SEGMENTS);
    end else begin
      cfg_o.segs = segment_count_q;
    end
  end

endmodule

// ===== src/ctig_step.sv =====
module ctig_step import ctig_pkg::*; (
  input  ctig_cfg_t   cfg_i,
  input  ctig_state_t state_i,
  input  logic        restart_i,
  output ctig_state_t state_o,
  output ctig_tri_t   tri_o
);

  ctig_state_t          cur;
  logic                 seg_last;
  logic                 ring_last;
  logic [IDX_W-1:0]     sp;
  logic [IDX_W-1:0]     segs_x;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     right;
  logic [2*CNT_W-1:0]   prod;
  logic [IDX_W-1:0]     apex;

  always_comb begin
    cur       = restart_i ? SEQ_RESET : state_i;
    seg_last  = CNT_W'(cur.seg_pos) >= (cfg_i.segs - CNT_W'(1));
    ring_last = CNT_W'(cur.ring_pos) >= (cfg_i.rings - CNT_W'(2));
    sp        = IDX_W'(cur.seg_pos);
    segs_x    = IDX_W'(cfg_i.segs);
    idx       = cur.row_base + sp;
    // last segment wraps back to the ring start
    right     = seg_last ? (idx + IDX_W'(1) - segs_x) : (idx + IDX_W'(1));
    prod      = (2*CNT_W)'(cfg_i.rings) * (2*CNT_W)'(cfg_i.segs);
    apex      = IDX_W'(prod) + IDX_W'(1);

    state_o       = cur;
    tri_o         = '0;

    case (cur.region)
      REG_TOP: begin
        tri_o.corner_a = '0;
        tri_o.corner_b = seg_last ? IDX_W'(1) : (sp + IDX_W'(2));
        tri_o.corner_c = sp + IDX_W'(1);
        if (seg_last) begin
          state_o        = SEQ_RESET;
          state_o.region = REG_BAND;
        end else begin
          state_o.seg_pos = cur.seg_pos + 1'b1;
        end
      end
      REG_BAND: begin
        if (!cur.band_half) begin
          tri_o.corner_a    = idx;
          tri_o.corner_b    = right;
          tri_o.corner_c    = idx + segs_x;
          state_o.band_half = 1'b1;
        end else begin
          tri_o.corner_a    = right;
          tri_o.corner_b    = right + segs_x;
          tri_o.corner_c    = idx + segs_x;
          state_o.band_half = 1'b0;
          if (seg_last) begin
            state_o.seg_pos = '0;
            if (ring_last) begin
              state_o.region   = REG_BOTTOM;
              state_o.ring_pos = '0;
            end else begin
              state_o.ring_pos = cur.ring_pos + 1'b1;
              state_o.row_base = cur.row_base + segs_x;
            end
          end else begin
            state_o.seg_pos = cur.seg_pos + 1'b1;
          end
        end
      end
      default: begin
        // bottom cap fan, winding reversed
        tri_o.corner_a = apex;
        tri_o.corner_b = seg_last ? (apex - IDX_W'(1)) : (apex - sp - IDX_W'(2));
        tri_o.corner_c = apex - sp - IDX_W'(1);
        if (seg_last) begin
          tri_o.mesh_last = 1'b1;
          state_o         = SEQ_RESET;
        end else begin
          state_o.seg_pos = cur.seg_pos + 1'b1;
        end
      end
    endcase
  end

endmodule

// ===== src/cylinder_triangle_index_generator.sv =====
// channel  dir  transfer when      payload
// in_i     in   valid && ready     restart
// out_o    out  valid && ready     corner_a, corner_b, corner_c, mesh_last
// cfg_i    in   valid && ready     index, data (always ready)
//
// one triangle per cycle unless the output stalls: input register, one pass of counter
// and index logic, output register; output valid is registered behind the input register
// the longest path is the 9x9 apex multiply followed by the apex add and corner subtracts
// rst_ni clears the sequence to the first top cap triangle, rings 2, segments 3
// a stalled output holds its triangle; the input register stays full meanwhile
module cylinder_triangle_index_generator import ctig_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctig_in_if.sink    in_i,
  ctig_out_if.source out_o,
  ctig_cfg_if.sink   cfg_i
);

  ctig_cfg_t   cfg;
  ctig_state_t state_q, state_d;
  ctig_tri_t   tri_d, tri_q;
  logic        in_vld_q;
  logic        restart_q;
  logic        out_vld_q;
  logic        adv;

  ctig_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ctig_step u_step (
    .cfg_i     (cfg),
    .state_i   (state_q),
    .restart_i (restart_q),
    .state_o   (state_d),
    .tri_o     (tri_d)
  );

  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= SEQ_RESET;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      restart_q <= in_i.restart;
    end
    if (adv) begin
      tri_q <= tri_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.corner_a  = tri_q.corner_a;
  assign out_o.corner_b  = tri_q.corner_b;
  assign out_o.corner_c  = tri_q.corner_c;
  assign out_o.mesh_last = tri_q.mesh_last;

endmodule

// ===== src/ctig_checker.sv =====
`include "assert_macros.svh"

module ctig_checker import ctig_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [IDX_W-1:0] corner_a_i,
  input logic [IDX_W-1:0] corner_b_i,
  input logic             mesh_last_i
);

  logic out_xfer;
  logic out_stall;

  assign out_xfer  = out_valid_i && out_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  `CHK_ASSERT_ALWAYS(a_no_valid_in_reset, clk_i, !rst_ni |=> !out_valid_i)
  `CHK_ASSERT(a_valid_held, clk_i, rst_ni, out_stall |=> out_valid_i)
  `CHK_ASSERT(a_payload_held, clk_i, rst_ni, out_stall |=> $stable({corner_a_i, corner_b_i, mesh_last_i}))
  // final triangle closes the bottom fan next to the apex
  `CHK_ASSERT(a_last_shape, clk_i, rst_ni, out_xfer && mesh_last_i |-> corner_b_i == corner_a_i - IDX_W'(1))
  // top cap triangles never end the mesh
  `CHK_ASSERT(a_top_not_last, clk_i, rst_ni, out_xfer && corner_a_i == '0 |-> !mesh_last_i)

endmodule

bind cylinder_triangle_index_generator ctig_checker u_ctig_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .corner_a_i  (out_o.corner_a),
  .corner_b_i  (out_o.corner_b),
  .mesh_last_i (out_o.mesh_last)
);

// ===== tb/tb_cylinder_triangle_index_generator.sv =====
`timescale 1ns / 100ps

module tb_cylinder_triangle_index_generator;
  import ctig_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int RANDOM_ITEMS = 1250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ctig_in_if  in_if ();
  ctig_out_if out_if ();
  ctig_cfg_if cfg_if ();

  cylinder_triangle_index_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // mesh walker state and register copies
  logic [CNT_W-1:0] reg_rings;
  logic [CNT_W-1:0] reg_segs;
  region_e          mesh_region;
  int unsigned      mesh_ring;
  int unsigned      mesh_seg;
  bit               mesh_half;
  int unsigned      mesh_row_base;

  bit        restart_q[$];
  ctig_tri_t triangle_q[$];

  int cycle_cnt;
  int mismatch_cnt;
  int triangles_checked;
  int meshes_done;
  int restarts_sent;
  int reg_writes;

  function automatic void rewind_mesh();
    mesh_region   = REG_TOP;
    mesh_ring     = 0;
    mesh_seg      = 0;
    mesh_half     = 1'b0;
    mesh_row_base = 1;
  endfunction

  function automatic int unsigned used_rings();
    if (reg_rings < 2) return 2;
    if (reg_rings > MAX_RINGS) return MAX_RINGS;
    return 32'(reg_rings);
  endfunction

  function automatic int unsigned used_segs();
    if (reg_segs < 3) return 3;
    if (reg_segs > MAX_SEGMENTS) return MAX_SEGMENTS;
    return 32'(reg_segs);
  endfunction

  function automatic ctig_tri_t next_triangle(bit restart);
    int unsigned rings, segs, idx, right, apex, a, b, c;
    bit          seg_end, ring_end;
    ctig_tri_t   t;
    rings = used_rings();
    segs  = used_segs();
    if (restart) rewind_mesh();
    seg_end   = mesh_seg >= segs - 1;
    ring_end  = mesh_ring >= rings - 2;
    t.mesh_last = 1'b0;
    case (mesh_region)
      REG_TOP: begin
        a = 0;
        b = seg_end ? 1 : mesh_seg + 2;
        c = mesh_seg + 1;
        if (seg_end) begin
          mesh_seg      = 0;
          mesh_region   = REG_BAND;
          mesh_ring     = 0;
          mesh_half     = 1'b0;
          mesh_row_base = 1;
        end else begin
          mesh_seg++;
        end
      end
      REG_BAND: begin
        idx   = mesh_row_base + mesh_seg;
        // last segment wraps to the start of the ring
        right = seg_end ? idx + 1 - segs : idx + 1;
        if (!mesh_half) begin
          a = idx;
          b = right;
          c = idx + segs;
          mesh_half = 1'b1;
        end else begin
          a = right;
          b = right + segs;
          c = idx + segs;
          mesh_half = 1'b0;
          if (seg_end) begin
            mesh_seg = 0;
            if (ring_end) begin
              mesh_region = REG_BOTTOM;
              mesh_ring   = 0;
            end else begin
              mesh_ring++;
              mesh_row_base += segs;
            end
          end else begin
            mesh_seg++;
          end
        end
      end
      default: begin
        apex = rings * segs + 1;
        a = apex;
        b = seg_end ? apex - 1 : apex - mesh_seg - 2;
        c = apex - mesh_seg - 1;
        if (seg_end) begin
          t.mesh_last = 1'b1;
          rewind_mesh();
        end else begin
          mesh_seg++;
        end
      end
    endcase
    t.corner_a = IDX_W'(a);
    t.corner_b = IDX_W'(b);
    t.corner_c = IDX_W'(c);
    return t;
  endfunction

  // input side: bursts of random length, the short ones separated by random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.restart <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_if.valid && in_if.ready) triangle_q = {triangle_q, next_triangle(in_if.restart)};
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (restart_q.size() != 0) begin
          in_if.valid   <= 1'b1;
          in_if.restart <= restart_q.pop_front();
          if (burst_left <= 1) begin
            if ($urandom_range(3, 0) == 0) begin
              burst_left = $urandom_range(120, 40);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(8, 1);
              gap_left   = $urandom_range(6, 1);
            end
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output side: stall modes that change at random
  int       stall_left;
  int       stall_mode;
  bit [7:0] stall_pat;
  int       pat_pos;
  ctig_tri_t want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
      pat_pos    = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        triangles_checked++;
        if (out_if.mesh_last) meshes_done++;
        if (triangle_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] triangle with nothing expected: %0d %0d %0d last=%0b", $realtime,
                     out_if.corner_a, out_if.corner_b, out_if.corner_c, out_if.mesh_last);
        end else begin
          want = triangle_q.pop_front();
          if (out_if.corner_a !== want.corner_a || out_if.corner_b !== want.corner_b ||
              out_if.corner_c !== want.corner_c || out_if.mesh_last !== want.mesh_last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("[%0t] triangle mismatch: expected %0d %0d %0d last=%0b, got %0d %0d %0d last=%0b",
                       $realtime, want.corner_a, want.corner_b, want.corner_c, want.mesh_last,
                       out_if.corner_a, out_if.corner_b, out_if.corner_c, out_if.mesh_last);
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(3, 0);
        stall_left = $urandom_range(200, 20);
        stall_pat  = 8'($urandom_range(255, 1));
      end else begin
        stall_left--;
      end
      pat_pos = (pat_pos + 1) % 8;
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(1, 0));
        2:       out_if.ready <= ($urandom_range(3, 0) == 0);
        default: out_if.ready <= stall_pat[pat_pos];
      endcase
    end
  end

  task automatic push_item(bit restart);
    restart_q = {restart_q, restart};
    if (restart) restarts_sent++;
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CNT_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_RING_COUNT) reg_rings = val;
    else reg_segs = val;
    reg_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  // wait for every transfer to finish, then let the pipeline settle
  task automatic drain();
    while (restart_q.size() != 0 || in_if.valid || triangle_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int sent, n, kind, mesh_len;
    logic [CNT_W-1:0] r_val, s_val;
    bit lead;

    in_if.valid   = 1'b0;
    in_if.restart = 1'b0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_RING_COUNT;
    cfg_if.data   = '0;
    reg_rings = CNT_W'(2);
    reg_segs  = CNT_W'(3);
    rewind_mesh();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: full mesh, wrap to the first triangle, restart mid-cap
    for (int i = 0; i < 13; i++) push_item(1'b0);
    push_item(1'b1);
    push_item(1'b0);
    drain();

    // walk a small mesh into the bottom cap, then grow it to the largest apex
    write_reg(CFG_RING_COUNT, CNT_W'(2));
    write_reg(CFG_SEGMENT_COUNT, CNT_W'(3));
    push_item(1'b1);
    for (int i = 0; i < 8; i++) push_item(1'b0);
    drain();
    write_reg(CFG_RING_COUNT, CNT_W'(511));
    write_reg(CFG_SEGMENT_COUNT, CNT_W'(256));
    push_item(1'b0);
    push_item(1'b0);
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(9, 0);
      if (kind == 0) begin
        case ($urandom_range(3, 0))
          0:       r_val = CNT_W'(2);
          1:       r_val = CNT_W'(256);
          2:       r_val = CNT_W'(257);
          default: r_val = CNT_W'(511);
        endcase
        case ($urandom_range(3, 0))
          0:       s_val = CNT_W'(0);
          1:       s_val = CNT_W'(3);
          2:       s_val = CNT_W'(256);
          default: s_val = CNT_W'(511);
        endcase
        n = $urandom_range(120, 20);
      end else if (kind <= 2) begin
        r_val = CNT_W'($urandom_range(511, 0));
        s_val = CNT_W'($urandom_range(511, 0));
        n = $urandom_range(80, 10);
      end else begin
        r_val = CNT_W'($urandom_range(6, 0));
        s_val = CNT_W'($urandom_range(10, 0));
        mesh_len = 2 * (r_val < 2 ? 2 : r_val) * (s_val < 3 ? 3 : s_val);
        n = mesh_len * $urandom_range(2, 1) + $urandom_range(8, 0);
      end
      // sometimes leave one or both registers as they were; the walk continues mid-mesh
      if ($urandom_range(4, 0) != 0) write_reg(CFG_RING_COUNT, r_val);
      if ($urandom_range(4, 0) != 0) write_reg(CFG_SEGMENT_COUNT, s_val);
      lead = $urandom_range(1, 0);
      for (int i = 0; i < n; i++)
        push_item((i == 0 && lead) || $urandom_range(99, 0) < 3);
      sent += n;
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("checked %0d triangles, %0d complete meshes, %0d restarts", triangles_checked,
             meshes_done, restarts_sent);
    $display("%0d register writes, %0d mismatches", reg_writes, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ctig_pkg.sv
src/ctig_if.sv
src/ctig_cfg.sv
src/ctig_step.sv
src/cylinder_triangle_index_generator.sv
src/ctig_checker.sv
tb/tb_cylinder_triangle_index_generator.sv
